/* design/assert_macros.svh */
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* design/spwc_pkg.sv */
// Types and constants of the sensor pulse-width capture block.
package spwc_pkg;

    localparam int PHASE_COUNT   = 82;
    localparam int WIDTH_BITS    = 16;
    localparam int PHASE_BITS    = $clog2(PHASE_COUNT);
    localparam int HOLD_BITS     = 24;
    localparam int SETTLE_BITS   = 8;
    localparam int LIMIT_BITS    = 16;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 24;
    localparam int CMP_BITS      = (WIDTH_BITS + 1 > LIMIT_BITS) ? WIDTH_BITS + 1 : LIMIT_BITS;

    localparam logic [HOLD_BITS-1:0]   HIGH_HOLD_RST = HOLD_BITS'(500000);
    localparam logic [HOLD_BITS-1:0]   LOW_HOLD_RST  = HOLD_BITS'(20000);
    localparam logic [SETTLE_BITS-1:0] SETTLE_RST    = SETTLE_BITS'(50);
    localparam logic [LIMIT_BITS-1:0]  TIMEOUT_RST   = LIMIT_BITS'(32000);
    localparam logic [WIDTH_BITS-1:0]  WIDTH_MAX     = '1;
    localparam logic [PHASE_BITS-1:0]  LAST_PHASE    = PHASE_BITS'(PHASE_COUNT - 1);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_HIGH_HOLD = 2'd0,
        CFG_LOW_HOLD  = 2'd1,
        CFG_SETTLE    = 2'd2,
        CFG_TIMEOUT   = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE    = 3'd0,
        ST_HIGH    = 3'd1,
        ST_LOW     = 3'd2,
        ST_SETTLE  = 3'd3,
        ST_WAIT    = 3'd4,
        ST_MEASURE = 3'd5
    } t_seq_state;

    typedef struct packed {
        logic [HOLD_BITS-1:0]   high_hold;
        logic [HOLD_BITS-1:0]   low_hold;
        logic [SETTLE_BITS-1:0] settle;
        logic [LIMIT_BITS-1:0]  timeout_limit;
    } t_cfg;

    typedef struct packed {
        t_seq_state             state;
        logic [HOLD_BITS-1:0]   hold;
        logic [PHASE_BITS-1:0]  phase;
        logic [WIDTH_BITS-1:0]  width;
    } t_seq;

    typedef struct packed {
        logic                   drive_enable;
        logic                   drive_level;
        logic                   busy;
        logic                   width_valid;
        logic [PHASE_BITS-1:0]  phase_number;
        logic [WIDTH_BITS-1:0]  pulse_width;
        logic                   last_phase;
        logic                   timed_out;
    } t_result;

endpackage

/* design/spwc_cfg.sv */
// Configuration register file of the pulse-width capture block.
module spwc_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [spwc_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [spwc_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    output spwc_pkg::t_cfg                     o_cfg
);

    spwc_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.high_hold     <= spwc_pkg::HIGH_HOLD_RST;
            r_cfg.low_hold      <= spwc_pkg::LOW_HOLD_RST;
            r_cfg.settle        <= spwc_pkg::SETTLE_RST;
            r_cfg.timeout_limit <= spwc_pkg::TIMEOUT_RST;
        end else if (i_cfg_we) begin
            unique case (spwc_pkg::t_cfg_idx'(i_cfg_idx))
                spwc_pkg::CFG_HIGH_HOLD: begin
                    r_cfg.high_hold <= i_cfg_data[spwc_pkg::HOLD_BITS-1:0];
                end
                spwc_pkg::CFG_LOW_HOLD: begin
                    r_cfg.low_hold <= i_cfg_data[spwc_pkg::HOLD_BITS-1:0];
                end
                spwc_pkg::CFG_SETTLE: begin
                    r_cfg.settle <= i_cfg_data[spwc_pkg::SETTLE_BITS-1:0];
                end
                spwc_pkg::CFG_TIMEOUT: begin
                    r_cfg.timeout_limit <= i_cfg_data[spwc_pkg::LIMIT_BITS-1:0];
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* design/spwc_step.sv */
// Next-state and result logic for one sampling tick.
module spwc_step (
    input  spwc_pkg::t_cfg    i_cfg,
    input  spwc_pkg::t_seq    i_cur,
    input  logic              i_line,
    input  logic              i_start,
    output spwc_pkg::t_seq    o_nxt,
    output spwc_pkg::t_result o_res
);

    spwc_pkg::t_seq_state                 st;
    logic [spwc_pkg::HOLD_BITS-1:0]       tmr;
    logic [spwc_pkg::PHASE_BITS-1:0]      ph;
    logic [spwc_pkg::WIDTH_BITS-1:0]      wc;
    logic [spwc_pkg::CMP_BITS-1:0]        cnt_next;
    logic                                 hit;
    spwc_pkg::t_result                    res;

    always_comb begin
        st  = i_cur.state;
        tmr = i_cur.hold;
        ph  = i_cur.phase;
        wc  = i_cur.width;
        res = '0;

        // start on request from idle, then skip steps whose hold time is zero
        if (st == spwc_pkg::ST_IDLE && i_start) begin
            st  = spwc_pkg::ST_HIGH;
            tmr = i_cfg.high_hold;
        end
        if (st == spwc_pkg::ST_HIGH && tmr == '0) begin
            st  = spwc_pkg::ST_LOW;
            tmr = i_cfg.low_hold;
        end
        if (st == spwc_pkg::ST_LOW && tmr == '0) begin
            st  = spwc_pkg::ST_SETTLE;
            tmr = spwc_pkg::HOLD_BITS'(i_cfg.settle);
        end
        if (st == spwc_pkg::ST_SETTLE && tmr == '0) begin
            st = spwc_pkg::ST_WAIT;
            wc = '0;
        end

        cnt_next = spwc_pkg::CMP_BITS'(wc) + spwc_pkg::CMP_BITS'(1);
        hit      = (cnt_next >= spwc_pkg::CMP_BITS'(i_cfg.timeout_limit)) ||
                   (cnt_next >= spwc_pkg::CMP_BITS'(spwc_pkg::WIDTH_MAX));

        unique case (st)
            spwc_pkg::ST_IDLE: begin
                tmr = '0;
                ph  = '0;
                wc  = '0;
            end
            spwc_pkg::ST_HIGH: begin
                tmr              = tmr - spwc_pkg::HOLD_BITS'(1);
                res.drive_enable = 1'b1;
                res.drive_level  = 1'b1;
            end
            spwc_pkg::ST_LOW: begin
                tmr              = tmr - spwc_pkg::HOLD_BITS'(1);
                res.drive_enable = 1'b1;
            end
            spwc_pkg::ST_SETTLE: begin
                tmr = tmr - spwc_pkg::HOLD_BITS'(1);
            end
            spwc_pkg::ST_WAIT: begin
                if (i_line) begin
                    if (hit) begin
                        st            = spwc_pkg::ST_IDLE;
                        tmr           = '0;
                        ph            = '0;
                        wc            = '0;
                        res.timed_out = 1'b1;
                    end else begin
                        wc = cnt_next[spwc_pkg::WIDTH_BITS-1:0];
                    end
                end else begin
                    st = spwc_pkg::ST_MEASURE;
                    ph = '0;
                    wc = spwc_pkg::WIDTH_BITS'(1);
                end
            end
            spwc_pkg::ST_MEASURE: begin
                if (i_line == ph[0]) begin
                    if (hit) begin
                        res.phase_number = ph;
                        res.timed_out    = 1'b1;
                        st               = spwc_pkg::ST_IDLE;
                        tmr              = '0;
                        ph               = '0;
                        wc               = '0;
                    end else begin
                        wc = cnt_next[spwc_pkg::WIDTH_BITS-1:0];
                    end
                end else begin
                    res.width_valid  = 1'b1;
                    res.phase_number = ph;
                    res.pulse_width  = wc;
                    if (ph >= spwc_pkg::LAST_PHASE) begin
                        res.last_phase = 1'b1;
                        st             = spwc_pkg::ST_IDLE;
                        tmr            = '0;
                        ph             = '0;
                        wc             = '0;
                    end else begin
                        ph = ph + spwc_pkg::PHASE_BITS'(1);
                        wc = spwc_pkg::WIDTH_BITS'(1);
                    end
                end
            end
            default: begin
                st  = spwc_pkg::ST_IDLE;
                tmr = '0;
                ph  = '0;
                wc  = '0;
            end
        endcase

        res.busy = (st != spwc_pkg::ST_IDLE);
    end

    assign o_nxt.state = st;
    assign o_nxt.hold  = tmr;
    assign o_nxt.phase = ph;
    assign o_nxt.width = wc;
    assign o_res       = res;

endmodule

/* design/sensor_pulse_width_capture.sv */
// Top level of the sensor pulse-width capture block.
//
//  channel  direction  handshake                  payload
//  in       sink       i_in_valid / o_in_ready    i_line_level, i_start_request
//  out      source     o_out_valid / i_out_ready  o_drive_enable .. o_timed_out
//  cfg      sink       i_cfg_we                   i_cfg_idx, i_cfg_data
//
//  One beat per cycle sustained while the out channel is not stalled.
//  The input register feeds the step logic, which updates the sequence registers
//  and loads the result register in the same cycle.
//  A stalled result register holds the input register; the input side stalls only
//  when both are full. Reset is synchronous and leaves the sequencer idle.
`include "assert_macros.svh"

module sensor_pulse_width_capture (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [spwc_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [spwc_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_line_level,
    input  logic                               i_start_request,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic                               o_drive_enable,
    output logic                               o_drive_level,
    output logic                               o_busy_res,
    output logic                               o_width_valid,
    output logic [spwc_pkg::PHASE_BITS-1:0]    o_phase_number,
    output logic [spwc_pkg::WIDTH_BITS-1:0]    o_pulse_width,
    output logic                               o_last_phase,
    output logic                               o_timed_out
);

    spwc_pkg::t_cfg    w_cfg;
    spwc_pkg::t_seq    r_seq;
    spwc_pkg::t_seq    n_seq;
    spwc_pkg::t_result n_res;
    spwc_pkg::t_result r_out;
    logic              r_out_valid;
    logic              r_in_valid;
    logic              r_in_line;
    logic              r_in_start;
    logic              w_adv;

    spwc_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    spwc_step u_step (
        .i_cfg   (w_cfg),
        .i_cur   (r_seq),
        .i_line  (r_in_line),
        .i_start (r_in_start),
        .o_nxt   (n_seq),
        .o_res   (n_res)
    );

    assign w_adv      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_line  <= i_line_level;
            r_in_start <= i_start_request;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq <= '0;
        end else if (w_adv) begin
            r_seq <= n_seq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= n_res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_drive_enable = r_out.drive_enable;
    assign o_drive_level  = r_out.drive_level;
    assign o_busy_res     = r_out.busy;
    assign o_width_valid  = r_out.width_valid;
    assign o_phase_number = r_out.phase_number;
    assign o_pulse_width  = r_out.pulse_width;
    assign o_last_phase   = r_out.last_phase;
    assign o_timed_out    = r_out.timed_out;

    `ASSERT_IMPLIES(a_no_width_on_timeout, i_clk, i_rst_n,
        o_out_valid && o_timed_out, !o_width_valid)
    `ASSERT_IMPLIES(a_last_is_final, i_clk, i_rst_n, o_out_valid && o_last_phase,
        o_width_valid && (o_phase_number == spwc_pkg::LAST_PHASE) && !o_busy_res)
    `ASSERT_IMPLIES(a_drive_when_busy, i_clk, i_rst_n,
        o_out_valid && o_drive_enable, o_busy_res)
    `ASSERT_NEXT(a_end_goes_idle, i_clk, i_rst_n,
        w_adv && (n_res.timed_out || n_res.last_phase), r_seq.state == spwc_pkg::ST_IDLE)

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for the sensor pulse-width capture block.
`timescale 1ns / 1ps

module tb_top;

    localparam int    HALF_PERIOD  = 4;
    localparam int    RESET_CYCLES = 6;
    localparam int    SETTLE_OUT   = 8;
    localparam int    RANDOM_BEATS = 2000;
    localparam int    SCRIPT_ROWS  = 22;
    localparam time   RUN_LIMIT    = 24_000_000;

    typedef enum logic {ROW_BEAT, ROW_REGS} t_row_kind;

    typedef struct {
        t_row_kind          kind;
        logic               line;
        logic               start;
        logic               typed;
        spwc_pkg::t_result  res;
        spwc_pkg::t_cfg     regs;
    } t_tick_row;

    typedef enum logic [1:0] {
        READY_ALWAYS, READY_COIN, READY_SPARSE, READY_PERIODIC
    } t_ready_mode;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               i_cfg_we = 1'b0;
    logic [spwc_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx = '0;
    logic [spwc_pkg::CFG_DATA_BITS-1:0] i_cfg_data = '0;
    logic                               i_in_valid = 1'b0;
    logic                               o_in_ready;
    logic                               i_line_level = 1'b0;
    logic                               i_start_request = 1'b0;
    logic                               o_out_valid;
    logic                               i_out_ready = 1'b0;
    logic                               o_drive_enable;
    logic                               o_drive_level;
    logic                               o_busy_res;
    logic                               o_width_valid;
    logic [spwc_pkg::PHASE_BITS-1:0]    o_phase_number;
    logic [spwc_pkg::WIDTH_BITS-1:0]    o_pulse_width;
    logic                               o_last_phase;
    logic                               o_timed_out;

    sensor_pulse_width_capture DUT (.*);

    // predicted sequencer and register copy
    spwc_pkg::t_seq_state              seq_st;
    logic [spwc_pkg::HOLD_BITS-1:0]    hold_left;
    logic [spwc_pkg::PHASE_BITS-1:0]   phase_idx;
    logic [spwc_pkg::WIDTH_BITS-1:0]   width_cnt;
    logic [spwc_pkg::HOLD_BITS-1:0]    cfg_high;
    logic [spwc_pkg::HOLD_BITS-1:0]    cfg_low;
    logic [spwc_pkg::SETTLE_BITS-1:0]  cfg_settle;
    logic [spwc_pkg::LIMIT_BITS-1:0]   cfg_limit;

    spwc_pkg::t_result capture_results_q[$];
    int                mismatches = 0;
    int                seq_beats = 0;
    int                burst_left = 0;
    bit                gaps_on = 1'b0;
    t_ready_mode       ready_mode = READY_ALWAYS;
    int                ready_hold = 0;
    t_tick_row         script [SCRIPT_ROWS];

    always begin
        #(HALF_PERIOD) i_clk = 1'b1;
        #(HALF_PERIOD) i_clk = 1'b0;
    end

    function automatic void seq_to_idle();
        seq_st    = spwc_pkg::ST_IDLE;
        hold_left = '0;
        phase_idx = '0;
        width_cnt = '0;
    endfunction

    function automatic void reset_capture();
        cfg_high   = spwc_pkg::HIGH_HOLD_RST;
        cfg_low    = spwc_pkg::LOW_HOLD_RST;
        cfg_settle = spwc_pkg::SETTLE_RST;
        cfg_limit  = spwc_pkg::TIMEOUT_RST;
        seq_to_idle();
    endfunction

    function automatic logic width_at_limit();
        int unsigned nxt;
        nxt = int'(width_cnt) + 1;
        if (nxt >= cfg_limit || nxt >= spwc_pkg::WIDTH_MAX) begin
            return 1'b1;
        end
        width_cnt = spwc_pkg::WIDTH_BITS'(nxt);
        return 1'b0;
    endfunction

    function automatic spwc_pkg::t_result capture_step(input logic line, input logic start);
        spwc_pkg::t_result r;
        logic              done;
        r    = '0;
        done = 1'b0;
        if (seq_st == spwc_pkg::ST_IDLE && start) begin
            seq_st    = spwc_pkg::ST_HIGH;
            hold_left = cfg_high;
        end
        while (!done) begin
            case (seq_st)
                spwc_pkg::ST_HIGH: begin
                    if (hold_left == 0) begin
                        seq_st    = spwc_pkg::ST_LOW;
                        hold_left = cfg_low;
                    end else begin
                        hold_left--;
                        r.drive_enable = 1'b1;
                        r.drive_level  = 1'b1;
                        done           = 1'b1;
                    end
                end
                spwc_pkg::ST_LOW: begin
                    if (hold_left == 0) begin
                        seq_st    = spwc_pkg::ST_SETTLE;
                        hold_left = spwc_pkg::HOLD_BITS'(cfg_settle);
                    end else begin
                        hold_left--;
                        r.drive_enable = 1'b1;
                        done           = 1'b1;
                    end
                end
                spwc_pkg::ST_SETTLE: begin
                    if (hold_left == 0) begin
                        seq_st    = spwc_pkg::ST_WAIT;
                        width_cnt = '0;
                    end else begin
                        hold_left--;
                        done = 1'b1;
                    end
                end
                spwc_pkg::ST_WAIT: begin
                    if (line) begin
                        if (width_at_limit()) begin
                            seq_to_idle();
                            r.timed_out = 1'b1;
                        end
                    end else begin
                        seq_st    = spwc_pkg::ST_MEASURE;
                        phase_idx = '0;
                        width_cnt = spwc_pkg::WIDTH_BITS'(1);
                    end
                    done = 1'b1;
                end
                spwc_pkg::ST_MEASURE: begin
                    if (line == phase_idx[0]) begin
                        if (width_at_limit()) begin
                            r.phase_number = phase_idx;
                            r.timed_out    = 1'b1;
                            seq_to_idle();
                        end
                    end else begin
                        r.width_valid  = 1'b1;
                        r.phase_number = phase_idx;
                        r.pulse_width  = width_cnt;
                        if (int'(phase_idx) + 1 >= spwc_pkg::PHASE_COUNT) begin
                            r.last_phase = 1'b1;
                            seq_to_idle();
                        end else begin
                            phase_idx++;
                            width_cnt = spwc_pkg::WIDTH_BITS'(1);
                        end
                    end
                    done = 1'b1;
                end
                default: begin
                    seq_to_idle();
                    done = 1'b1;
                end
            endcase
        end
        r.busy = (seq_st != spwc_pkg::ST_IDLE);
        return r;
    endfunction

    function automatic spwc_pkg::t_result flags_res(logic de, logic dl, logic busy, logic to,
                                                    logic [spwc_pkg::PHASE_BITS-1:0] ph);
        spwc_pkg::t_result r;
        r              = '0;
        r.drive_enable = de;
        r.drive_level  = dl;
        r.busy         = busy;
        r.timed_out    = to;
        r.phase_number = ph;
        return r;
    endfunction

    function automatic t_tick_row beat_row(logic line, logic start);
        t_tick_row r;
        r.kind  = ROW_BEAT;
        r.line  = line;
        r.start = start;
        r.typed = 1'b0;
        r.res   = '0;
        r.regs  = '0;
        return r;
    endfunction

    function automatic t_tick_row chk_row(logic line, logic start, spwc_pkg::t_result res);
        t_tick_row r;
        r       = beat_row(line, start);
        r.typed = 1'b1;
        r.res   = res;
        return r;
    endfunction

    function automatic t_tick_row regs_row(logic [spwc_pkg::HOLD_BITS-1:0] h,
                                           logic [spwc_pkg::HOLD_BITS-1:0] l,
                                           logic [spwc_pkg::SETTLE_BITS-1:0] s,
                                           logic [spwc_pkg::LIMIT_BITS-1:0] t);
        t_tick_row r;
        r                    = beat_row(1'b0, 1'b0);
        r.kind               = ROW_REGS;
        r.regs.high_hold     = h;
        r.regs.low_hold      = l;
        r.regs.settle        = s;
        r.regs.timeout_limit = t;
        return r;
    endfunction

    function automatic void check_field(string name, longint unsigned want,
                                        longint unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    task automatic send_beat(input logic line, input logic start,
                             input logic typed = 1'b0,
                             input spwc_pkg::t_result typed_res = '0);
        spwc_pkg::t_result predicted;
        i_in_valid      <= 1'b1;
        i_line_level    <= line;
        i_start_request <= start;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = capture_step(line, start);
        capture_results_q.push_back(typed ? typed_res : predicted);
    endtask

    task automatic pace();
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if (gaps_on) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
        burst_left--;
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (capture_results_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_OUT) @(posedge i_clk);
    endtask

    task automatic poke(input spwc_pkg::t_cfg_idx idx,
                        input logic [spwc_pkg::CFG_DATA_BITS-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            spwc_pkg::CFG_HIGH_HOLD: cfg_high = data;
            spwc_pkg::CFG_LOW_HOLD: cfg_low = data;
            spwc_pkg::CFG_SETTLE: cfg_settle = data[spwc_pkg::SETTLE_BITS-1:0];
            spwc_pkg::CFG_TIMEOUT: cfg_limit = data[spwc_pkg::LIMIT_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic program_regs(input logic [spwc_pkg::CFG_DATA_BITS-1:0] h,
                                input logic [spwc_pkg::CFG_DATA_BITS-1:0] l,
                                input logic [spwc_pkg::CFG_DATA_BITS-1:0] s,
                                input logic [spwc_pkg::CFG_DATA_BITS-1:0] t);
        drain_results();
        poke(spwc_pkg::CFG_HIGH_HOLD, h);
        poke(spwc_pkg::CFG_LOW_HOLD, l);
        poke(spwc_pkg::CFG_SETTLE, s);
        poke(spwc_pkg::CFG_TIMEOUT, t);
        i_cfg_we <= 1'b0;
    endtask

    function automatic int pick_width(bit broken);
        int cap;
        cap = (cfg_limit <= 1) ? 1 : int'(cfg_limit) - 1;
        if (cap > 6) cap = 6;
        if (broken && $urandom_range(0, 5) == 0) begin
            return int'(cfg_limit) + 1;
        end
        return $urandom_range(1, cap);
    endfunction

    task automatic run_capture(input bit broken);
        int   want;
        int   want_ph;
        int   wait_want;
        int   cap;
        logic line;
        logic start;
        want    = 0;
        want_ph = -1;
        cap     = (cfg_limit == 0) ? 0 : int'(cfg_limit) - 1;
        if (cap > 3) cap = 3;
        wait_want = $urandom_range(0, cap);
        pace();
        send_beat(1'($urandom_range(0, 1)), 1'b1);
        seq_beats++;
        while (seq_st != spwc_pkg::ST_IDLE) begin
            case (seq_st)
                spwc_pkg::ST_WAIT: line = (int'(width_cnt) < wait_want);
                spwc_pkg::ST_MEASURE: begin
                    if (int'(phase_idx) != want_ph) begin
                        want    = pick_width(broken);
                        want_ph = int'(phase_idx);
                    end
                    line = (int'(width_cnt) < want) ? phase_idx[0] : ~phase_idx[0];
                end
                default: line = 1'($urandom_range(0, 1));
            endcase
            if (broken && $urandom_range(0, 4) == 0) line = 1'($urandom_range(0, 1));
            start = ($urandom_range(0, 7) == 0);
            pace();
            send_beat(line, start);
            seq_beats++;
        end
    endtask

    always @(posedge i_clk) begin
        if (ready_hold == 0) begin
            ready_mode <= t_ready_mode'($urandom_range(0, 3));
            ready_hold <= $urandom_range(50, 400);
        end else begin
            ready_hold <= ready_hold - 1;
        end
        case (ready_mode)
            READY_ALWAYS: i_out_ready <= 1'b1;
            READY_COIN: i_out_ready <= 1'($urandom_range(0, 1));
            READY_SPARSE: i_out_ready <= ($urandom_range(0, 3) == 0);
            default: i_out_ready <= (ready_hold % 5 != 0);
        endcase
    end

    always @(posedge i_clk) begin
        spwc_pkg::t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (capture_results_q.size() == 0) begin
                $error("result beat with nothing expected");
                mismatches++;
            end else begin
                want = capture_results_q.pop_front();
                check_field("drive_enable", 64'(want.drive_enable), 64'(o_drive_enable));
                check_field("drive_level", 64'(want.drive_level), 64'(o_drive_level));
                check_field("busy_res", 64'(want.busy), 64'(o_busy_res));
                check_field("width_valid", 64'(want.width_valid), 64'(o_width_valid));
                check_field("phase_number", 64'(want.phase_number), 64'(o_phase_number));
                check_field("pulse_width", 64'(want.pulse_width), 64'(o_pulse_width));
                check_field("last_phase", 64'(want.last_phase), 64'(o_last_phase));
                check_field("timed_out", 64'(want.timed_out), 64'(o_timed_out));
            end
        end
    end

    initial begin
        #(RUN_LIMIT);
        $display("sensor_pulse_width_capture regression: fail");
        $finish;
    end

    initial begin
        int                                 limit;
        int unsigned                        sv;
        logic [spwc_pkg::CFG_DATA_BITS-1:0] h;
        logic [spwc_pkg::CFG_DATA_BITS-1:0] l;
        reset_capture();
        script = '{
            chk_row(1'b0, 1'b0, flags_res(1'b0, 1'b0, 1'b0, 1'b0, '0)),
            chk_row(1'b1, 1'b0, flags_res(1'b0, 1'b0, 1'b0, 1'b0, '0)),
            regs_row(24'd1, 24'd1, 8'd1, 16'd2),
            chk_row(1'b1, 1'b1, flags_res(1'b1, 1'b1, 1'b1, 1'b0, '0)),
            chk_row(1'b0, 1'b1, flags_res(1'b1, 1'b0, 1'b1, 1'b0, '0)),
            chk_row(1'b0, 1'b0, flags_res(1'b0, 1'b0, 1'b1, 1'b0, '0)),
            beat_row(1'b1, 1'b0),
            chk_row(1'b1, 1'b1, flags_res(1'b0, 1'b0, 1'b0, 1'b1, '0)),
            chk_row(1'b0, 1'b0, flags_res(1'b0, 1'b0, 1'b0, 1'b0, '0)),
            regs_row(24'd0, 24'd0, 8'd0, 16'd0),
            beat_row(1'b0, 1'b1),
            chk_row(1'b0, 1'b0, flags_res(1'b0, 1'b0, 1'b0, 1'b1, '0)),
            regs_row(24'd0, 24'd0, 8'd0, 16'd5),
            beat_row(1'b0, 1'b1),
            beat_row(1'b1, 1'b0),
            beat_row(1'b1, 1'b1),
            beat_row(1'b0, 1'b0),
            beat_row(1'b0, 1'b0),
            beat_row(1'b0, 1'b0),
            beat_row(1'b0, 1'b0),
            chk_row(1'b0, 1'b1, flags_res(1'b0, 1'b0, 1'b0, 1'b1, spwc_pkg::PHASE_BITS'(2))),
            chk_row(1'b1, 1'b0, flags_res(1'b0, 1'b0, 1'b0, 1'b0, '0))
        };
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[k]) begin
            if (script[k].kind == ROW_REGS) begin
                program_regs(script[k].regs.high_hold, script[k].regs.low_hold,
                             spwc_pkg::CFG_DATA_BITS'(script[k].regs.settle),
                             spwc_pkg::CFG_DATA_BITS'(script[k].regs.timeout_limit));
            end else begin
                send_beat(script[k].line, script[k].start, script[k].typed, script[k].res);
            end
        end

        // largest register values, idle beats only
        program_regs('1, '1, '1, '1);
        gaps_on = 1'b1;
        repeat (16) begin
            pace();
            send_beat(1'($urandom_range(0, 1)), 1'b0);
        end

        while (seq_beats < RANDOM_BEATS) begin
            h = ($urandom_range(0, 7) == 0) ? spwc_pkg::CFG_DATA_BITS'($urandom_range(0, 40))
                                            : spwc_pkg::CFG_DATA_BITS'($urandom_range(0, 3));
            l = ($urandom_range(0, 7) == 0) ? spwc_pkg::CFG_DATA_BITS'($urandom_range(0, 40))
                                            : spwc_pkg::CFG_DATA_BITS'($urandom_range(0, 3));
            sv = ($urandom_range(0, 9) == 0) ? 255 : $urandom_range(0, 3);
            case ($urandom_range(0, 9))
                0: limit = $urandom_range(1, 3);
                1: limit = $urandom_range(17, 300);
                default: limit = $urandom_range(4, 16);
            endcase
            program_regs(h, l, {16'($urandom), 8'(sv)}, {8'($urandom), 16'(limit)});
            gaps_on = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(1, 2)) begin
                repeat ($urandom_range(0, 3)) begin
                    pace();
                    send_beat(1'($urandom_range(0, 1)), 1'b0);
                end
                run_capture($urandom_range(0, 4) == 0);
            end
        end

        drain_results();
        if (mismatches == 0) begin
            $display("sensor_pulse_width_capture regression: pass");
        end else begin
            $display("sensor_pulse_width_capture regression: fail");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+design
design/spwc_pkg.sv
design/spwc_cfg.sv
design/spwc_step.sv
design/sensor_pulse_width_capture.sv
verif/tb_top.sv
